// ===== src/n2cn_pkg.sv =====
// n2cn_pkg: symbol codes, control word layout and control program of the
// chinese numeral speller. no dependencies.
`timescale 1ns / 1ps
package n2cn_pkg;

  // symbol codes
  localparam int unsigned SymW = 4;
  localparam logic [SymW-1:0] SymZero     = 4'd0;
  localparam logic [SymW-1:0] SymTen      = 4'd10;
  localparam logic [SymW-1:0] SymHundred  = 4'd11;
  localparam logic [SymW-1:0] SymThousand = 4'd12;
  localparam logic [SymW-1:0] SymWan      = 4'd13;
  localparam logic [SymW-1:0] SymYi       = 4'd14;

  // datapath sizes
  localparam int unsigned ValueW    = 32;
  localparam int unsigned NumDigits = 10;
  localparam int unsigned BcdW      = 4 * NumDigits;
  localparam int unsigned ConvSteps = ValueW / 2;   // two bits per cycle
  localparam int unsigned ConvCntW  = $clog2(ConvSteps);
  localparam int unsigned MaxSyms   = 19;
  localparam int unsigned OutCntW   = $clog2(MaxSyms + 1);
  localparam int unsigned PcW       = 5;

  // program labels
  localparam logic [PcW-1:0] LblSect1 = 5'd8;
  localparam logic [PcW-1:0] LblGap1  = 5'd17;
  localparam logic [PcW-1:0] LblEnd   = 5'd26;

  // control word operations
  typedef enum logic [2:0] {
    OP_NOP   = 3'd0,
    OP_CONV  = 3'd1,   // binary to bcd, two bits a cycle
    OP_ZCHK  = 3'd2,   // zero value gives one zero symbol
    OP_DIGIT = 3'd3,   // digit, or zero inside a section
    OP_UNIT  = 3'd4,   // ten / hundred / thousand after a nonzero digit
    OP_SECU  = 3'd5,   // wan / yi after a nonzero section
    OP_GAP   = 3'd6,   // zero between sections
    OP_END   = 3'd7    // flush the held symbol as the last one
  } op_e;

  // jump conditions
  typedef enum logic [2:0] {
    COND_NONE       = 3'd0,
    COND_CONV_BUSY  = 3'd1,
    COND_VALUE_ZERO = 3'd2,
    COND_DIGIT_ZERO = 3'd3,
    COND_SECT_ZERO  = 3'd4
  } cond_e;

  typedef struct packed {
    op_e            op;
    cond_e          cond;
    logic [3:0]     arg;      // digit position or section number
    logic [SymW-1:0] sym;     // unit symbol
    logic [PcW-1:0] target;   // jump target
  } uword_t;

  function automatic uword_t mk(op_e op, cond_e c, logic [3:0] a, logic [SymW-1:0] s,
                                logic [PcW-1:0] t);
    uword_t w;
    w.op     = op;
    w.cond   = c;
    w.arg    = a;
    w.sym    = s;
    w.target = t;
    return w;
  endfunction

  // control program, one word per step
  function automatic uword_t ucode(logic [PcW-1:0] pc);
    uword_t w;
    case (pc)
      5'd0:  w = mk(OP_CONV,  COND_CONV_BUSY,  4'd0, SymZero,     5'd0);
      5'd1:  w = mk(OP_ZCHK,  COND_VALUE_ZERO, 4'd0, SymZero,     LblEnd);
      // yi section
      5'd2:  w = mk(OP_NOP,   COND_SECT_ZERO,  4'd2, SymZero,     LblSect1);
      5'd3:  w = mk(OP_DIGIT, COND_DIGIT_ZERO, 4'd9, SymZero,     5'd5);
      5'd4:  w = mk(OP_UNIT,  COND_NONE,       4'd9, SymTen,      5'd0);
      5'd5:  w = mk(OP_DIGIT, COND_NONE,       4'd8, SymZero,     5'd0);
      5'd6:  w = mk(OP_SECU,  COND_NONE,       4'd2, SymYi,       5'd0);
      5'd7:  w = mk(OP_GAP,   COND_NONE,       4'd2, SymZero,     5'd0);
      // wan section
      5'd8:  w = mk(OP_NOP,   COND_SECT_ZERO,  4'd1, SymZero,     LblGap1);
      5'd9:  w = mk(OP_DIGIT, COND_DIGIT_ZERO, 4'd7, SymZero,     5'd11);
      5'd10: w = mk(OP_UNIT,  COND_NONE,       4'd7, SymThousand, 5'd0);
      5'd11: w = mk(OP_DIGIT, COND_DIGIT_ZERO, 4'd6, SymZero,     5'd13);
      5'd12: w = mk(OP_UNIT,  COND_NONE,       4'd6, SymHundred,  5'd0);
      5'd13: w = mk(OP_DIGIT, COND_DIGIT_ZERO, 4'd5, SymZero,     5'd15);
      5'd14: w = mk(OP_UNIT,  COND_NONE,       4'd5, SymTen,      5'd0);
      5'd15: w = mk(OP_DIGIT, COND_NONE,       4'd4, SymZero,     5'd0);
      5'd16: w = mk(OP_SECU,  COND_NONE,       4'd1, SymWan,      5'd0);
      5'd17: w = mk(OP_GAP,   COND_NONE,       4'd1, SymZero,     5'd0);
      // low section
      5'd18: w = mk(OP_NOP,   COND_SECT_ZERO,  4'd0, SymZero,     LblEnd);
      5'd19: w = mk(OP_DIGIT, COND_DIGIT_ZERO, 4'd3, SymZero,     5'd21);
      5'd20: w = mk(OP_UNIT,  COND_NONE,       4'd3, SymThousand, 5'd0);
      5'd21: w = mk(OP_DIGIT, COND_DIGIT_ZERO, 4'd2, SymZero,     5'd23);
      5'd22: w = mk(OP_UNIT,  COND_NONE,       4'd2, SymHundred,  5'd0);
      5'd23: w = mk(OP_DIGIT, COND_DIGIT_ZERO, 4'd1, SymZero,     5'd25);
      5'd24: w = mk(OP_UNIT,  COND_NONE,       4'd1, SymTen,      5'd0);
      5'd25: w = mk(OP_DIGIT, COND_NONE,       4'd0, SymZero,     5'd0);
      default: w = mk(OP_END, COND_NONE,       4'd0, SymZero,     5'd0);
    endcase
    return w;
  endfunction

endpackage

// ===== src/number_to_chinese_numerals_top.sv =====
// operation: bcd conversion first, then one program step per cycle (up to 26 steps);
// symbol beats leave after the start beat, at most one a cycle.
// busy from the start beat to the last symbol, and a new value is not taken while busy;
// busy time is set by the two-bits-per-cycle bcd converter and the control program length.
// reset: rst_ni low clears the sequencer and the strobe; the block comes up idle.
// the receiver cannot stall: each symbol stands on the ports for exactly one cycle.
`timescale 1ns / 1ps
module number_to_chinese_numerals_top import n2cn_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [ValueW-1:0] value_i,
  output logic              symbol_valid_o,
  output logic [SymW-1:0]   symbol_o,
  output logic              last_o
);

  // control registers
  logic                busy_q, busy_d;
  logic [PcW-1:0]      pc_q, pc_d;
  logic [ConvCntW-1:0] cnt_q, cnt_d;
  logic                pend_v_q, pend_v_d;
  logic [OutCntW-1:0]  ocnt_q, ocnt_d;
  logic                ovalid_q, ovalid_d;

  // payload registers
  logic [ValueW-1:0]   bin_q, bin_d;
  logic [BcdW-1:0]     bcd_q, bcd_d;
  logic [SymW-1:0]     pend_sym_q, pend_sym_d;
  logic [SymW-1:0]     osym_q, osym_d;
  logic                olast_q, olast_d;

  // datapath signals
  uword_t              uw;
  logic [3:0]          dig [NumDigits];
  logic [3:0]          dig_sel;
  logic [2:0]          sect_nz;
  logic                val_zero;
  logic                prev_nz, below_nz, gap;
  logic [3:0]          base;
  logic [BcdW-1:0]     bcd_c;
  logic [ValueW-1:0]   bin_c;
  logic                emit, fin, jump;
  logic [SymW-1:0]     emit_sym;

  assign uw = ucode(pc_q);

  // digit view of the bcd word
  always_comb begin
    for (int j = 0; j < NumDigits; j++) begin
      dig[j] = bcd_q[4*j +: 4];
    end
  end

  assign sect_nz[0] = |bcd_q[15:0];
  assign sect_nz[1] = |bcd_q[31:16];
  assign sect_nz[2] = |bcd_q[BcdW-1:32];
  assign val_zero   = ~|bcd_q;
  assign base       = {uw.arg[3:2], 2'b00};

  // selected digit and its neighbors inside the section
  always_comb begin
    dig_sel  = 4'd0;
    prev_nz  = 1'b0;
    below_nz = 1'b0;
    for (int j = 0; j < NumDigits; j++) begin
      if (4'(j) == uw.arg) begin
        dig_sel = dig[j];
      end
      if (({1'b0, uw.arg} + 5'd1 == 5'(j)) && (uw.arg[1:0] != 2'd3) && (dig[j] != 4'd0)) begin
        prev_nz = 1'b1;
      end
      if ((4'(j) >= base) && (4'(j) < uw.arg) && (dig[j] != 4'd0)) begin
        below_nz = 1'b1;
      end
    end
  end

  // zero between sections
  always_comb begin
    if (uw.arg[1:0] == 2'd2) begin
      gap = sect_nz[2] && sect_nz[1] && (dig[7] == 4'd0);
    end else begin
      gap = (sect_nz[2] || sect_nz[1]) && sect_nz[0] && (dig[3] == 4'd0);
    end
  end

  // double dabble, two bits a cycle
  always_comb begin
    bcd_c = bcd_q;
    bin_c = bin_q;
    for (int s = 0; s < 2; s++) begin
      for (int n = 0; n < NumDigits; n++) begin
        if (bcd_c[4*n +: 4] >= 4'd5) begin
          bcd_c[4*n +: 4] = bcd_c[4*n +: 4] + 4'd3;
        end
      end
      bcd_c = {bcd_c[BcdW-2:0], bin_c[ValueW-1]};
      bin_c = {bin_c[ValueW-2:0], 1'b0};
    end
  end

  // control word decode
  always_comb begin
    emit     = 1'b0;
    fin      = 1'b0;
    emit_sym = SymZero;
    unique case (uw.op) inside
      OP_NOP, OP_CONV: begin
      end
      OP_ZCHK: begin
        emit = val_zero;
      end
      OP_DIGIT: begin
        if (dig_sel != 4'd0) begin
          emit     = 1'b1;
          emit_sym = dig_sel;
        end else begin
          emit = prev_nz && below_nz;
        end
      end
      OP_UNIT: begin
        emit     = (dig_sel != 4'd0);
        emit_sym = uw.sym;
      end
      OP_SECU: begin
        emit     = sect_nz[uw.arg[1:0]];
        emit_sym = uw.sym;
      end
      OP_GAP: begin
        emit = gap;
      end
      OP_END: begin
        fin = 1'b1;
      end
      default: begin
        fin = 1'b1;
      end
    endcase
  end

  // jump condition
  always_comb begin
    unique case (uw.cond)
      COND_NONE:       jump = 1'b0;
      COND_CONV_BUSY:  jump = (cnt_q != ConvCntW'(ConvSteps - 1));
      COND_VALUE_ZERO: jump = val_zero;
      COND_DIGIT_ZERO: jump = (dig_sel == 4'd0);
      COND_SECT_ZERO:  jump = !sect_nz[uw.arg[1:0]];
      default:         jump = 1'b0;
    endcase
  end

  // sequencer, held symbol and output stage
  always_comb begin
    busy_d     = busy_q;
    pc_d       = pc_q;
    cnt_d      = cnt_q;
    pend_v_d   = pend_v_q;
    pend_sym_d = pend_sym_q;
    ocnt_d     = ocnt_q;
    bin_d      = bin_q;
    bcd_d      = bcd_q;
    ovalid_d   = 1'b0;
    osym_d     = osym_q;
    olast_d    = olast_q;
    if (!busy_q) begin
      if (start) begin
        busy_d   = 1'b1;
        pc_d     = '0;
        cnt_d    = '0;
        pend_v_d = 1'b0;
        ocnt_d   = '0;
        bin_d    = value_i;
        bcd_d    = '0;
      end
    end else begin
      if (uw.op == OP_CONV) begin
        bcd_d = bcd_c;
        bin_d = bin_c;
        cnt_d = cnt_q + ConvCntW'(1);
      end
      pc_d = jump ? uw.target : pc_q + PcW'(1);
      if (fin) begin
        // held symbol goes out as the last one
        ovalid_d = pend_v_q;
        osym_d   = pend_sym_q;
        olast_d  = 1'b1;
        pend_v_d = 1'b0;
        busy_d   = 1'b0;
      end else if (emit) begin
        pend_v_d   = 1'b1;
        pend_sym_d = emit_sym;
        if (pend_v_q) begin
          ovalid_d = 1'b1;
          osym_d   = pend_sym_q;
          olast_d  = (ocnt_q == OutCntW'(MaxSyms - 1));
          ocnt_d   = ocnt_q + OutCntW'(1);
          // spelling is cut at the symbol limit
          if (ocnt_q == OutCntW'(MaxSyms - 1)) begin
            busy_d   = 1'b0;
            pend_v_d = 1'b0;
          end
        end
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      pc_q     <= '0;
      cnt_q    <= '0;
      pend_v_q <= 1'b0;
      ocnt_q   <= '0;
      ovalid_q <= 1'b0;
    end else begin
      busy_q   <= busy_d;
      pc_q     <= pc_d;
      cnt_q    <= cnt_d;
      pend_v_q <= pend_v_d;
      ocnt_q   <= ocnt_d;
      ovalid_q <= ovalid_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    bin_q      <= bin_d;
    bcd_q      <= bcd_d;
    pend_sym_q <= pend_sym_d;
    osym_q     <= osym_d;
    olast_q    <= olast_d;
  end

  assign busy           = busy_q;
  assign symbol_valid_o = ovalid_q;
  assign symbol_o       = osym_q;
  assign last_o         = olast_q;

endmodule

// ===== tb/number_to_chinese_numerals_top_test.sv =====
// number_to_chinese_numerals_top_test: self-checking bench for the chinese numeral speller.
// predicts the symbol beats of each value locally and compares them against the dut.
// depends on n2cn_pkg and number_to_chinese_numerals_top.
`timescale 1ns / 1ps
module number_to_chinese_numerals_top_test;
  import n2cn_pkg::*;

  typedef struct {
    logic [ValueW-1:0] value;
    logic [SymW-1:0]   sym;
    logic              last;
  } symbol_beat_t;

  localparam int unsigned MaxReports = 50;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              start;
  logic              busy;
  logic [ValueW-1:0] value_i;
  logic              symbol_valid_o;
  logic [SymW-1:0]   symbol_o;
  logic              last_o;

  symbol_beat_t      pending_symbols[$];
  logic [SymW-1:0]   spell_buf[$];
  symbol_beat_t      oldest_beat;
  int unsigned       mismatches = 0;

  number_to_chinese_numerals_top i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .value_i        (value_i),
    .symbol_valid_o (symbol_valid_o),
    .symbol_o       (symbol_o),
    .last_o         (last_o)
  );

  // 100 MHz clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // run limit
  initial begin
    #5ms;
    $display("Mismatches found");
    $finish;
  end

  // spell one four-digit section into spell_buf; a zero section spells nothing
  function automatic void spell_section(int unsigned sec);
    int unsigned d[4];
    int          top;
    bit          lower_nz;
    bit          upper_nz;
    d[0] = sec % 10;
    d[1] = (sec / 10) % 10;
    d[2] = (sec / 100) % 10;
    d[3] = (sec / 1000) % 10;
    top = -1;
    for (int i = 3; i >= 0; i--) begin
      if (top < 0 && d[i] != 0) top = i;
    end
    for (int i = top; i >= 0; i--) begin
      if (d[i] != 0) begin
        spell_buf.push_back(SymW'(d[i]));
        case (i)
          1: spell_buf.push_back(SymTen);
          2: spell_buf.push_back(SymHundred);
          3: spell_buf.push_back(SymThousand);
          default: ;
        endcase
      end else begin
        // one zero for a run of zeros between nonzero digits
        upper_nz = (i < 3) ? (d[i+1] != 0) : 1'b0;
        lower_nz = 1'b0;
        for (int j = i - 1; j >= 0; j--) begin
          if (d[j] != 0) lower_nz = 1'b1;
        end
        if (upper_nz && lower_nz) spell_buf.push_back(SymZero);
      end
    end
  endfunction

  // spell a whole value and queue its expected symbol beats
  function automatic void spell_value(logic [ValueW-1:0] v);
    int unsigned sec[3];
    int          top;
    int          n;
    symbol_beat_t beat;
    spell_buf.delete();
    if (v == 0) begin
      spell_buf.push_back(SymZero);
    end else begin
      sec[0] = v % 10000;
      sec[1] = (v / 10000) % 10000;
      sec[2] = v / 100000000;
      top = 0;
      for (int k = 2; k >= 0; k--) begin
        if (top == 0 && sec[k] != 0) top = k;
      end
      for (int k = top; k >= 0; k--) begin
        spell_section(sec[k]);
        if (sec[k] != 0 && k > 0) spell_buf.push_back(k == 1 ? SymWan : SymYi);
        // zero between sections when the lower one is short
        if (k > 0 && sec[k-1] > 0 && sec[k-1] < 1000) spell_buf.push_back(SymZero);
      end
    end
    n = (spell_buf.size() > MaxSyms) ? MaxSyms : spell_buf.size();
    for (int k = 0; k < n; k++) begin
      beat.value = v;
      beat.sym   = spell_buf[k];
      beat.last  = (k == n - 1);
      pending_symbols.push_back(beat);
    end
  endfunction

  function automatic void report_mismatch(string what, logic [ValueW-1:0] v,
                                          int unsigned exp_val, int unsigned act_val);
    mismatches++;
    if (mismatches <= MaxReports)
      $display("%0t ns: value %0d %s expected %0d actual %0d",
               $time, v, what, exp_val, act_val);
  endfunction

  // symbol beat checker
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && symbol_valid_o !== 1'b0) begin
      if (pending_symbols.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display("%0t ns: unexpected beat, expected none, actual sym %0d last %0d",
                   $time, symbol_o, last_o);
      end else begin
        oldest_beat = pending_symbols.pop_front();
        if (symbol_o !== oldest_beat.sym)
          report_mismatch("symbol", oldest_beat.value, oldest_beat.sym, symbol_o);
        if (last_o !== oldest_beat.last)
          report_mismatch("last", oldest_beat.value, oldest_beat.last, last_o);
      end
    end
  end

  // hold start low with junk on the value bus, repeated n times
  task automatic idle_cycles(int unsigned n);
    repeat (n) begin
      @(negedge clk_i);
      start   <= 1'b0;
      value_i <= $urandom;
    end
  endtask

  // present one value and wait for the start beat to be taken
  task automatic send_value(logic [ValueW-1:0] v);
    @(negedge clk_i);
    start   <= 1'b1;
    value_i <= v;
    forever begin
      @(posedge clk_i);
      if (busy === 1'b0) break;
    end
    spell_value(v);
  endtask

  task automatic wait_all_symbols();
    idle_cycles(1);
    while (pending_symbols.size() != 0) @(posedge clk_i);
  endtask

  // build a value from decimal digits, each one zero half of the time
  function automatic logic [ValueW-1:0] sparse_digits();
    longint unsigned acc;
    acc = 0;
    for (int i = 0; i < NumDigits; i++) begin
      acc = acc * 10 + (($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 9));
    end
    if (acc > 64'hFFFF_FFFF) acc = acc % 1000000000;
    return ValueW'(acc);
  endfunction

  // compose a value from yi, wan and low sections of chosen shapes
  function automatic logic [ValueW-1:0] section_mix();
    int unsigned sec[3];
    for (int k = 0; k < 3; k++) begin
      case ($urandom_range(0, 3))
        0: sec[k] = 0;
        1: sec[k] = $urandom_range(1, 999);
        2: sec[k] = $urandom_range(1000, 9999);
        default: sec[k] = $urandom_range(1, 9) * (10 ** $urandom_range(0, 3));
      endcase
    end
    sec[2] = sec[2] % 43;
    return ValueW'(longint'(sec[2]) * 100000000 + sec[1] * 10000 + sec[0]);
  endfunction

  // extremes and the zero rules, back to back
  task automatic test_directed();
    logic [ValueW-1:0] vals[] = '{
      32'd0, 32'd1, 32'd10, 32'd11, 32'd20, 32'd100, 32'd101, 32'd110,
      32'd1000, 32'd1001, 32'd1010, 32'd9999, 32'd10000, 32'd10001, 32'd100000,
      32'd100000000, 32'd100000001, 32'd100001000, 32'd100010000, 32'd1000010,
      32'd200000300, 32'd10100, 32'd2147483648, 32'd4000000000, 32'hFFFF_FFFF
    };
    foreach (vals[i]) send_value(vals[i]);
  endtask

  // after every third value the sender holds off until every beat in flight has come back
  task automatic test_drain_pause();
    for (int i = 0; i < 10; i++) begin
      send_value(section_mix());
      if (i % 3 == 2) wait_all_symbols();
    end
    wait_all_symbols();
  endtask

  // random values in bursts, with a random gap after a burst half of the time
  task automatic test_random(int unsigned count);
    int unsigned sent;
    int unsigned burst;
    logic [ValueW-1:0] v;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 12);
      for (int b = 0; b < burst && sent < count; b++) begin
        case ($urandom_range(0, 3))
          0: v = $urandom;
          1: v = sparse_digits();
          2: v = $urandom_range(0, 20000);
          default: v = section_mix();
        endcase
        send_value(v);
        sent++;
      end
      if ($urandom_range(0, 1) == 1) idle_cycles($urandom_range(1, 40));
    end
  endtask

  initial begin
    rst_ni  = 1'b0;
    start   = 1'b0;
    value_i = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    idle_cycles(2);

    test_directed();
    test_drain_pause();
    test_random(325);

    wait_all_symbols();
    repeat (50) @(posedge clk_i);
    if (mismatches == 0 && pending_symbols.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
